[sv/spq_pkg.sv]
// Shared types, constants and fixed-point log2 helpers for the scale pitch quantizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned NUM_RATIOS   = 7;
  localparam int unsigned SCALE_SIZE_D = 7;
  localparam int unsigned OCT_COUNT_D  = 10;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned LOG_STEPS    = 16;

  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned RATIO_W = 18;
  localparam int unsigned BASE_W  = 13;
  localparam int unsigned PROD_W  = BASE_W + RATIO_W;
  localparam int unsigned LOG_W   = 5 + FRAC_BITS;
  localparam int unsigned LIN_W   = LOG_W + 1;
  localparam int unsigned DIST_W  = 24;

  localparam logic [FREQ_W-1:0] BASE_LIMIT = 24'd7680;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = 24'hFFFFFF;
  localparam logic [LIN_W-1:0]  LIN_OFFSET = LIN_W'(16) << FRAC_BITS;

  // Register index on the configuration port.
  localparam logic [2:0] REG_HOME = 3'd0;

  typedef logic [LOG_W-1:0] log_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BASE = 4'b0010,
    ST_NORM = 4'b0100,
    ST_SQ   = 4'b1000
  } eng_state_e;

  function automatic logic [4:0] msb_idx(input logic [PROD_W-1:0] x);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < int'(PROD_W); i++) begin
      if (x[i]) k = 5'(i);
    end
    return k;
  endfunction

  // Mantissa with the leading one moved to bit 31.
  function automatic logic [31:0] norm_mant(input logic [PROD_W-1:0] x, input logic [4:0] k);
    return {1'b0, x} << (5'd31 - k);
  endfunction

  // One squaring step of the log2 fraction: returns {fraction bit, new mantissa}.
  function automatic logic [32:0] sq_step(input logic [31:0] m);
    logic [63:0] sq;
    logic [32:0] t;
    sq = 64'(m) * 64'(m);
    t  = sq[63:31];
    if (t[32]) return {1'b1, t[32:1]};
    else return {1'b0, t[31:0]};
  endfunction

  // Halve the home frequency until it is at most BASE_LIMIT.
  function automatic logic [BASE_W-1:0] reduce_base(input logic [FREQ_W-1:0] h);
    logic [FREQ_W-1:0] b;
    b = h;
    for (int s = 12; s >= 0; s--) begin
      if ((h >> s) <= BASE_LIMIT) b = h >> s;
    end
    return b[BASE_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/spq_if.sv]
// Valid/ready channel interfaces for the scale pitch quantizer.
// Depends on spq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] in_freq;
  modport source (output valid, in_freq, input ready);
  modport sink   (input valid, in_freq, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] note_freq;
  logic [2:0]        scale_index;
  logic [3:0]        octave_index;
  modport source (output valid, note_freq, scale_index, octave_index, input ready);
  modport sink   (input valid, note_freq, scale_index, octave_index, output ready);
endinterface

`default_nettype wire

[sv/scale_pitch_quantizer.sv]
// Top level of the scale pitch quantizer: APB registers, candidate log engine, item pipeline.
// Depends on spq_pkg and the channel interfaces in spq_if.sv.
//
//   channel   dir   handshake        payload
//   in_i      in    valid/ready      in_freq
//   out_o     out   valid/ready      note_freq, scale_index, octave_index
//   apb       in    psel/penable     paddr, pwdata, prdata
//
// One item per cycle enters a 20-stage pipeline: normalize, 16 squaring stages
// (one 32x32 multiplier each), per-ratio octave pick, ratio min, note rounding.
// After reset and after every register write the candidate logs are rebuilt by a
// shared squaring unit, one ratio after another; input is held off while it runs.
// A stall at the output freezes every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module scale_pitch_quantizer import spq_pkg::*; #(
  parameter int unsigned SCALE_SIZE   = SCALE_SIZE_D,
  parameter int unsigned OCTAVE_COUNT = OCT_COUNT_D
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  spq_in_if.sink           in_i,
  spq_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned NS = LOG_STEPS + 1;
  localparam logic [3:0]  OCT_LAST = 4'(OCTAVE_COUNT - 1);
  localparam logic [2:0]  IDX_LAST = 3'(SCALE_SIZE - 1);

  // ---------------- registers ----------------
  logic [FREQ_W-1:0]  home_q;
  logic [RATIO_W-1:0] ratio_q [NUM_RATIOS];
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q     <= 24'd128000;
      ratio_q[0] <= 18'd73728;
      ratio_q[1] <= 18'd81920;
      ratio_q[2] <= 18'd87381;
      ratio_q[3] <= 18'd98304;
      ratio_q[4] <= 18'd109227;
      ratio_q[5] <= 18'd122880;
      ratio_q[6] <= 18'd131072;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_HOME) home_q <= pwdata[FREQ_W-1:0];
      else ratio_q[cfg_idx - 3'd1] <= pwdata[RATIO_W-1:0];
    end
  end

  always_comb begin
    if (cfg_idx == REG_HOME) prdata = {8'd0, home_q};
    else prdata = {14'd0, ratio_q[cfg_idx - 3'd1]};
  end

  // ---------------- candidate log engine ----------------
  eng_state_e         st_q;
  logic [BASE_W-1:0]  base_q;
  logic [2:0]         eidx_q;
  logic [3:0]         ecnt_q;
  logic [4:0]         ek_q;
  logic [31:0]        em_q;
  logic [FRAC_BITS-1:0] efrac_q;
  log_t               lc_q   [NUM_RATIOS];
  logic [PROD_W-1:0]  prod_q [NUM_RATIOS];
  logic [PROD_W-1:0]  eprod;
  logic [4:0]         ek;
  logic [32:0]        estep;
  logic               busy;

  assign eprod = PROD_W'(base_q) * PROD_W'(ratio_q[eidx_q]);
  assign ek    = msb_idx(eprod);
  assign estep = sq_step(em_q);
  assign busy  = (st_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_BASE;
      eidx_q <= '0;
      ecnt_q <= '0;
    end else if (cfg_wr) begin
      st_q <= ST_BASE;
    end else begin
      unique case (st_q)
        ST_IDLE: st_q <= ST_IDLE;
        ST_BASE: begin
          eidx_q <= '0;
          st_q   <= ST_NORM;
        end
        ST_NORM: begin
          ecnt_q <= '0;
          st_q   <= ST_SQ;
        end
        ST_SQ: begin
          ecnt_q <= ecnt_q + 4'd1;
          if (ecnt_q == 4'(LOG_STEPS - 1)) begin
            eidx_q <= eidx_q + 3'd1;
            st_q   <= (eidx_q == IDX_LAST) ? ST_IDLE : ST_NORM;
          end
        end
        default: st_q <= ST_BASE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_BASE) base_q <= reduce_base(home_q);
    if (st_q == ST_NORM) begin
      prod_q[eidx_q] <= eprod;
      ek_q           <= ek;
      em_q           <= norm_mant(eprod, ek);
      efrac_q        <= '0;
    end
    if (st_q == ST_SQ) begin
      em_q    <= estep[31:0];
      efrac_q <= {efrac_q[FRAC_BITS-2:0], estep[32]};
      if (ecnt_q == 4'(LOG_STEPS - 1)) lc_q[eidx_q] <= {ek_q, efrac_q[FRAC_BITS-2:0], estep[32]};
    end
  end

  // ---------------- item pipeline ----------------
  logic                 en;
  logic                 acc;
  logic                 lv_q   [NS];
  logic                 lz_q   [NS];
  logic [4:0]           lk_q   [NS];
  logic [31:0]          lm_q   [NS];
  logic [FRAC_BITS-1:0] lf_q   [NS];
  logic [32:0]          lstep  [LOG_STEPS];
  logic [PROD_W-1:0]    fin;
  logic [4:0]           fk;

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en && !busy;
  assign acc        = in_i.valid && in_i.ready;
  assign fin        = PROD_W'(in_i.in_freq);
  assign fk         = msb_idx(fin);

  // Each squaring stage yields one fraction bit and the next mantissa.
  always_comb begin
    for (int s = 0; s < int'(LOG_STEPS); s++) lstep[s] = sq_step(lm_q[s]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < int'(NS); s++) lv_q[s] <= 1'b0;
    end else if (en) begin
      lv_q[0] <= acc;
      for (int s = 1; s < int'(NS); s++) lv_q[s] <= lv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lz_q[0] <= (in_i.in_freq == '0);
      lk_q[0] <= fk;
      lm_q[0] <= norm_mant(fin, fk);
      lf_q[0] <= '0;
      for (int s = 1; s < int'(NS); s++) begin
        lz_q[s] <= lz_q[s-1];
        lk_q[s] <= lk_q[s-1];
        lm_q[s] <= lstep[s-1][31:0];
        lf_q[s] <= {lf_q[s-1][FRAC_BITS-2:0], lstep[s-1][32]};
      end
    end
  end

  // Stage A: best octave per ratio. The octave grid is uniform in log2, so
  // only the two neighbors of the input position can win; ties keep the lower.
  logic [LIN_W-1:0]  lin;
  logic              av_q;
  logic              az_q;
  logic              aok_q [NUM_RATIOS];
  logic [3:0]        ap_q  [NUM_RATIOS];
  logic [DIST_W-1:0] ad_q  [NUM_RATIOS];
  logic              aok   [NUM_RATIOS];
  logic [3:0]        ap    [NUM_RATIOS];
  logic [DIST_W-1:0] ad    [NUM_RATIOS];

  assign lin = {1'b0, lk_q[NS-1], lf_q[NS-1]} + LIN_OFFSET;

  always_comb begin
    logic signed [DIST_W-1:0] dl;
    logic [7:0]               q;
    for (int i = 0; i < int'(NUM_RATIOS); i++) begin
      dl = signed'(DIST_W'(lin)) - signed'(DIST_W'(lc_q[i]));
      q  = dl[DIST_W-1:FRAC_BITS];
      aok[i] = (i < int'(SCALE_SIZE)) && (ratio_q[i] != '0);
      if (dl < 0) begin
        ap[i] = '0;
        ad[i] = DIST_W'(-dl);
      end else if (q >= 8'(OCT_LAST)) begin
        ap[i] = OCT_LAST;
        ad[i] = DIST_W'(dl) - (DIST_W'(OCT_LAST) << FRAC_BITS);
      end else if (dl[FRAC_BITS-1:0] > 16'd32768) begin
        ap[i] = q[3:0] + 4'd1;
        ad[i] = (DIST_W'(1) << FRAC_BITS) - DIST_W'(dl[FRAC_BITS-1:0]);
      end else begin
        ap[i] = q[3:0];
        ad[i] = DIST_W'(dl[FRAC_BITS-1:0]);
      end
    end
  end

  // Stage B: first strictly smaller distance over ratios.
  logic       bv_q, bf_q;
  logic [2:0] bi_q;
  logic [3:0] bp_q;
  logic       bf;
  logic [2:0] bi;
  logic [3:0] bp;

  always_comb begin
    logic [DIST_W-1:0] best;
    bf   = 1'b0;
    bi   = '0;
    bp   = '0;
    best = '0;
    for (int i = 0; i < int'(NUM_RATIOS); i++) begin
      if (aok_q[i] && (!bf || ad_q[i] < best)) begin
        bf   = 1'b1;
        bi   = 3'(i);
        bp   = ap_q[i];
        best = ad_q[i];
      end
    end
    if (az_q || base_q == '0) bf = 1'b0;
  end

  // Stage C: note frequency, rounded half up and saturated.
  logic [PROD_W+15:0] nsh;
  logic [PROD_W+15:0] nrd;
  logic               cv_q;
  logic [FREQ_W-1:0]  cn_q;
  logic [2:0]         ci_q;
  logic [3:0]         cp_q;

  assign nsh = (PROD_W+16)'(prod_q[bi_q]) << bp_q;
  assign nrd = (nsh + (PROD_W+16)'(32768)) >> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0;
      bv_q <= 1'b0;
      cv_q <= 1'b0;
    end else if (en) begin
      av_q <= lv_q[NS-1];
      bv_q <= av_q;
      cv_q <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      az_q <= lz_q[NS-1];
      for (int i = 0; i < int'(NUM_RATIOS); i++) begin
        aok_q[i] <= aok[i];
        ap_q[i]  <= ap[i];
        ad_q[i]  <= ad[i];
      end
      bf_q <= bf;
      bi_q <= bf ? bi : 3'd0;
      bp_q <= bf ? bp : 4'd0;
      if (!bf_q) cn_q <= '0;
      else if (nrd > (PROD_W+16)'(FREQ_MAX)) cn_q <= FREQ_MAX;
      else cn_q <= nrd[FREQ_W-1:0];
      ci_q <= bi_q;
      cp_q <= bp_q;
    end
  end

  assign out_o.valid        = cv_q;
  assign out_o.note_freq    = cn_q;
  assign out_o.scale_index  = ci_q;
  assign out_o.octave_index = cp_q;

  // ---------------- assertions ----------------
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready) else $error("item accepted while candidate logs rebuild");

  a_scale_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.scale_index <= IDX_LAST)) else $error("scale index out of range");

  a_oct_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.octave_index <= OCT_LAST)) else $error("octave index out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv_q && !out_o.ready) |=> (cv_q && $stable(cn_q) && $stable(lv_q[0])))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
